// ===== rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// BFS shortest path package
// Operation codes, port widths and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int VERTEX_W = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef struct packed {
		logic latch;
		logic clr_graph;
		logic wr_edge;
		logic edge_sel_b;
		logic bfs_init;
		logic deq;
		logic row_rd;
		logic cand_load;
		logic enq;
		logic walk_init;
		logic push;
		logic walk_next;
		logic pop;
		logic emit_path;
		logic emit_nopath;
		logic emit_single;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  edge_ok;
		logic  a_eq_b;
		logic  queue_empty;
		logic  cand_any;
		logic  target_seen;
		logic  cur_is_src;
		logic  sp_zero;
	} sts_t;

endpackage

// ===== rtl/bfs_shortest_path_unit.sv =====
// ----------------------------------------------------------------------------
// BFS shortest path unit
// Holds an undirected graph as an adjacency matrix and answers shortest
// path queries with a breadth-first search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A query with an
// endpoint out of range or with source equal to target answers without a
// search. Otherwise each vertex taken from the queue costs a queue read, a
// matrix row read, a candidate load, an enqueue of each newly found
// neighbor and a closing scan step, and the search stops once the target
// is reached; the path is then walked back through the predecessor table
// and emitted. Results come one at a time, each on the result ports for
// exactly one cycle with result_valid high; the receiver cannot stall
// them, and last_in_path marks the final result of a query. The vertex
// count is written on the cfg channel, which is always ready, and must only
// be written while busy is low and no result is still due.
module bfs_shortest_path_unit #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [bsp_pkg::VERTEX_W-1:0]  first_vertex,
	input  logic [bsp_pkg::VERTEX_W-1:0]  second_vertex,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsp_pkg::COUNT_W-1:0]   cfg_data,
	output logic                          result_valid,
	output logic [bsp_pkg::VERTEX_W-1:0]  path_vertex,
	output logic                          last_in_path,
	output logic                          no_path
);

	bsp_pkg::cmd_t cmd;
	bsp_pkg::sts_t sts;
	logic          busy_w;

	assign cfg_ready = 1'b1;
	assign busy      = busy_w;

	bsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy_w),
		.cmd    (cmd)
	);

	bsp_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.cfg_we        (cfg_valid),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.result_valid  (result_valid),
		.path_vertex   (path_vertex),
		.last_in_path  (last_in_path),
		.no_path       (no_path)
	);

endmodule

// ===== rtl/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// BFS shortest path controller
// Sequences graph clears, edge loads, the breadth-first search, the
// predecessor walk and the output of the path.
// ----------------------------------------------------------------------------
module bsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bsp_pkg::sts_t sts,
	output logic          busy,
	output bsp_pkg::cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b0000_0000_0001,
		ST_DECODE    = 12'b0000_0000_0010,
		ST_EDGE_B    = 12'b0000_0000_0100,
		ST_DEQ       = 12'b0000_0000_1000,
		ST_ROW_RD    = 12'b0000_0001_0000,
		ST_SCAN_LOAD = 12'b0000_0010_0000,
		ST_SCAN      = 12'b0000_0100_0000,
		ST_CHECK     = 12'b0000_1000_0000,
		ST_PUSH      = 12'b0001_0000_0000,
		ST_WALK      = 12'b0010_0000_0000,
		ST_POP       = 12'b0100_0000_0000,
		ST_EMIT      = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.func)
					bsp_pkg::FUNC_CLEAR: begin
						cmd.clr_graph = 1'b1;
						state_d       = ST_IDLE;
					end
					bsp_pkg::FUNC_ADD: begin
						if (sts.edge_ok) begin
							cmd.wr_edge = 1'b1;
							state_d     = ST_EDGE_B;
						end else begin
							state_d = ST_IDLE;
						end
					end
					bsp_pkg::FUNC_QUERY: begin
						if (!sts.edge_ok) begin
							cmd.emit_nopath = 1'b1;
							state_d         = ST_IDLE;
						end else if (sts.a_eq_b) begin
							cmd.emit_single = 1'b1;
							state_d         = ST_IDLE;
						end else begin
							cmd.bfs_init = 1'b1;
							state_d      = ST_DEQ;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_EDGE_B: begin
				cmd.wr_edge    = 1'b1;
				cmd.edge_sel_b = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_DEQ: begin
				// Predecessors along the path never change once set, so the
				// search can stop as soon as the target has been reached.
				if (sts.queue_empty || sts.target_seen) begin
					state_d = ST_CHECK;
				end else begin
					cmd.deq = 1'b1;
					state_d = ST_ROW_RD;
				end
			end
			ST_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = ST_SCAN_LOAD;
			end
			ST_SCAN_LOAD: begin
				cmd.cand_load = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.cand_any) begin
					cmd.enq = 1'b1;
				end else begin
					state_d = ST_DEQ;
				end
			end
			ST_CHECK: begin
				if (sts.target_seen) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_PUSH;
				end else begin
					cmd.emit_nopath = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = sts.cur_is_src ? ST_POP : ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_next = 1'b1;
				state_d       = ST_PUSH;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_path = 1'b1;
				state_d       = sts.sp_zero ? ST_IDLE : ST_POP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/bsp_datapath.sv =====
// ----------------------------------------------------------------------------
// BFS shortest path datapath
// Adjacency matrix, search queue, predecessor table, path stack and the
// result registers, driven by the controller's commands.
// ----------------------------------------------------------------------------
module bsp_datapath #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    func,
	input  logic [bsp_pkg::VERTEX_W-1:0]  first_vertex,
	input  logic [bsp_pkg::VERTEX_W-1:0]  second_vertex,
	input  logic                          cfg_we,
	input  logic [bsp_pkg::COUNT_W-1:0]   cfg_data,
	input  bsp_pkg::cmd_t                 cmd,
	output bsp_pkg::sts_t                 sts,
	output logic                          result_valid,
	output logic [bsp_pkg::VERTEX_W-1:0]  path_vertex,
	output logic                          last_in_path,
	output logic                          no_path
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] ONE_V = MAX_VERTICES'(1);

	// Configuration and latched request.
	logic [CW-1:0]                 n_q;
	logic [1:0]                    func_q;
	logic [bsp_pkg::VERTEX_W-1:0]  a_q;
	logic [bsp_pkg::VERTEX_W-1:0]  b_q;
	logic [VW-1:0]                 a_idx;
	logic [VW-1:0]                 b_idx;

	// Graph storage.
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic                    row_ok_q;

	// Search state.
	logic [VW-1:0]           q_mem [MAX_VERTICES];
	logic [VW-1:0]           pred_mem [MAX_VERTICES];
	logic [VW-1:0]           stack_mem [MAX_VERTICES];
	logic [VW-1:0]           q_rd_q;
	logic [VW-1:0]           pred_rd_q;
	logic [VW-1:0]           stack_rd_q;
	logic [CW-1:0]           head_q;
	logic [CW-1:0]           tail_q;
	logic [CW-1:0]           sp_q;
	logic [CW-1:0]           sp_dec;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] cand_q;
	logic [VW-1:0]           cur_q;

	// Result registers.
	logic                         res_valid_q;
	logic [bsp_pkg::VERTEX_W-1:0] res_vertex_q;
	logic                         res_last_q;
	logic                         res_nopath_q;

	// Combinational helpers.
	logic [VW-1:0]           edge_row;
	logic [VW-1:0]           edge_col;
	logic [MAX_VERTICES-1:0] col_oh;
	logic [MAX_VERTICES-1:0] edge_mask;
	logic [MAX_VERTICES-1:0] src_oh;
	logic [MAX_VERTICES-1:0] lane_mask;
	logic [MAX_VERTICES-1:0] low_bit;
	logic [VW-1:0]           enq_idx;
	logic [VW-1:0]           q_waddr;
	logic [VW-1:0]           q_wdata;

	assign a_idx  = a_q[VW-1:0];
	assign b_idx  = b_q[VW-1:0];
	assign sp_dec = sp_q - CW'(1);

	always_comb begin
		edge_row = cmd.edge_sel_b ? b_idx : a_idx;
		edge_col = cmd.edge_sel_b ? a_idx : b_idx;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			col_oh[j]    = (edge_col == VW'(j));
			src_oh[j]    = (a_idx == VW'(j));
			lane_mask[j] = (CW'(j) < n_q);
		end
		// A row that has not been written since the last clear is rewritten
		// whole, so stale bits from an earlier graph never show.
		edge_mask = row_valid_q[edge_row] ? col_oh : '1;
	end

	// Lowest pending neighbor: isolate the lowest set bit, then encode it.
	always_comb begin
		low_bit = cand_q & (~cand_q + ONE_V);
		enq_idx = '0;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			if (low_bit[j]) begin
				enq_idx = enq_idx | VW'(j);
			end
		end
	end

	assign q_waddr = cmd.bfs_init ? '0 : tail_q[VW-1:0];
	assign q_wdata = cmd.bfs_init ? a_idx : enq_idx;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= CW'(MAX_VERTICES);
			row_valid_q <= '0;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_data > bsp_pkg::COUNT_W'(MAX_VERTICES)) begin
					n_q <= CW'(MAX_VERTICES);
				end else begin
					n_q <= cfg_data[CW-1:0];
				end
			end
			if (cmd.clr_graph) begin
				row_valid_q <= '0;
			end else if (cmd.wr_edge) begin
				row_valid_q[edge_row] <= 1'b1;
			end
			if (cmd.bfs_init) begin
				visited_q <= src_oh;
				head_q    <= '0;
				tail_q    <= CW'(1);
			end else begin
				if (cmd.enq) begin
					visited_q <= visited_q | low_bit;
					tail_q    <= tail_q + CW'(1);
				end
				if (cmd.deq) begin
					head_q <= head_q + CW'(1);
				end
			end
			if (cmd.walk_init) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q <= sp_q + CW'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_dec;
			end
			res_valid_q <= cmd.emit_path | cmd.emit_nopath | cmd.emit_single;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			a_q    <= first_vertex;
			b_q    <= second_vertex;
		end
		if (cmd.row_rd) begin
			cur_q <= q_rd_q;
		end else if (cmd.walk_init) begin
			cur_q <= b_idx;
		end else if (cmd.walk_next) begin
			cur_q <= pred_rd_q;
		end
		if (cmd.cand_load) begin
			cand_q <= (row_ok_q ? adj_rd_q : '0) & ~visited_q & lane_mask;
		end else if (cmd.enq) begin
			cand_q <= cand_q & ~low_bit;
		end
		if (cmd.emit_path) begin
			res_vertex_q <= bsp_pkg::VERTEX_W'(stack_rd_q);
			res_last_q   <= (sp_q == '0);
			res_nopath_q <= 1'b0;
		end else if (cmd.emit_single) begin
			res_vertex_q <= a_q;
			res_last_q   <= 1'b1;
			res_nopath_q <= 1'b0;
		end else if (cmd.emit_nopath) begin
			res_vertex_q <= '0;
			res_last_q   <= 1'b1;
			res_nopath_q <= 1'b1;
		end
	end

	// Adjacency matrix: bit-masked write, registered row read.
	always_ff @(posedge clk) begin
		if (cmd.wr_edge) begin
			for (int j = 0; j < MAX_VERTICES; j++) begin
				if (edge_mask[j]) begin
					adj_mem[edge_row][j] <= col_oh[j];
				end
			end
		end
		if (cmd.row_rd) begin
			adj_rd_q <= adj_mem[q_rd_q];
			row_ok_q <= row_valid_q[q_rd_q];
		end
	end

	// Search queue.
	always_ff @(posedge clk) begin
		if (cmd.bfs_init || cmd.enq) begin
			q_mem[q_waddr] <= q_wdata;
		end
		if (cmd.deq) begin
			q_rd_q <= q_mem[head_q[VW-1:0]];
		end
	end

	// Predecessor table. Entries are read only for vertices reached in the
	// current search, so they need no clearing.
	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			pred_mem[enq_idx] <= cur_q;
		end
		if (cmd.push) begin
			pred_rd_q <= pred_mem[cur_q];
		end
	end

	// Path stack.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[sp_q[VW-1:0]] <= cur_q;
		end
		if (cmd.pop) begin
			stack_rd_q <= stack_mem[sp_dec[VW-1:0]];
		end
	end

	always_comb begin
		sts.func        = bsp_pkg::func_t'(func_q);
		sts.edge_ok     = (bsp_pkg::COUNT_W'(a_q) < bsp_pkg::COUNT_W'(n_q)) &&
		                  (bsp_pkg::COUNT_W'(b_q) < bsp_pkg::COUNT_W'(n_q));
		sts.a_eq_b      = (a_q == b_q);
		sts.queue_empty = (head_q == tail_q);
		sts.cand_any    = |cand_q;
		sts.target_seen = visited_q[b_idx];
		sts.cur_is_src  = (cur_q == a_idx);
		sts.sp_zero     = (sp_q == '0);
	end

	assign result_valid = res_valid_q;
	assign path_vertex  = res_vertex_q;
	assign last_in_path = res_last_q;
	assign no_path      = res_nopath_q;

endmodule
